### rtl/vri_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vri_pkg
// Shared types and constants of the video register interface: action and
// register codes, memory sizes, palette mirroring and the beat payloads.
// ----------------------------------------------------------------------------
package vri_pkg;

  // Memory sizes
  localparam int SPRITE_MEM_BYTES_DEF = 256;
  localparam int PALETTE_BYTES_DEF    = 32;

  // Action codes carried on the input tuser
  typedef enum logic [1:0] {
    ACT_READ      = 2'd0,
    ACT_WRITE     = 2'd1,
    ACT_VBLANK    = 2'd2,
    ACT_PRERENDER = 2'd3
  } action_t;

  // Register numbers within the eight-register window
  localparam logic [2:0] REG_CTRL    = 3'd0;
  localparam logic [2:0] REG_MASK    = 3'd1;
  localparam logic [2:0] REG_STATUS  = 3'd2;
  localparam logic [2:0] REG_OAMADDR = 3'd3;
  localparam logic [2:0] REG_OAMDATA = 3'd4;
  localparam logic [2:0] REG_SCROLL  = 3'd5;
  localparam logic [2:0] REG_ADDR    = 3'd6;
  localparam logic [2:0] REG_DATA    = 3'd7;

  // Address map and masks
  localparam logic [13:0] PAL_BASE      = 14'h3F00;
  localparam logic [7:0]  ATTR_MASK     = 8'hE3;
  localparam logic [1:0]  ATTR_SLOT     = 2'd2;
  localparam logic [4:0]  PAL_MIR_SEL   = 5'h13;
  localparam logic [4:0]  PAL_MIR_HIT   = 5'h10;
  localparam logic [14:0] STEP_ACROSS   = 15'd1;
  localparam logic [14:0] STEP_DOWN     = 15'd32;

  // Control register bit positions
  localparam int CTRL_INC_BIT = 2;
  localparam int CTRL_NMI_BIT = 7;

  // One input beat
  typedef struct packed {
    action_t     action;
    logic [2:0]  reg_sel;
    logic [7:0]  write_byte;
    logic [7:0]  ext_byte;
    logic        oam_write_ok;
    logic [1:0]  sprite_flags;
  } in_item_t;

  // One result beat
  typedef struct packed {
    logic [7:0]  read_byte;
    logic        ext_read;
    logic        ext_write;
    logic [13:0] ext_addr;
    logic [7:0]  ext_data;
    logic        nmi_pulse;
    logic [14:0] cur_addr;
    logic [14:0] tmp_addr;
    logic [2:0]  fine_scroll_x;
    logic [7:0]  ctrl_value;
    logic [7:0]  mask_value;
  } out_item_t;

endpackage

### rtl/vri_sprite_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vri_sprite_mem
// Sprite attribute memory: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module vri_sprite_mem
  import vri_pkg::*;
#(
  parameter int SPRITE_MEM_BYTES = SPRITE_MEM_BYTES_DEF,
  localparam int SPR_AW = $clog2(SPRITE_MEM_BYTES)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [SPR_AW-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic [SPR_AW-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [SPRITE_MEM_BYTES];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/vri_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vri_core
// Register file and update logic: control, mask, status, scroll addresses,
// palette, read buffer and bus latch. One beat is applied per advance.
// ----------------------------------------------------------------------------
module vri_core
  import vri_pkg::*;
#(
  parameter int SPRITE_MEM_BYTES = SPRITE_MEM_BYTES_DEF,
  parameter int PALETTE_BYTES    = PALETTE_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  in_item_t  item,
  output out_item_t result
);

  localparam int SPR_AW = $clog2(SPRITE_MEM_BYTES);
  localparam int PAL_AW = $clog2(PALETTE_BYTES);

  // Architectural state
  logic [7:0]  ctrl, ctrl_next;
  logic [7:0]  mask, mask_next;
  logic        vblank, vblank_next;
  logic [7:0]  spr_addr, spr_addr_next;
  logic [14:0] cur, cur_next;
  logic [14:0] tmp, tmp_next;
  logic [2:0]  fine_x, fine_x_next;
  logic        toggle, toggle_next;
  logic [7:0]  rd_buf, rd_buf_next;
  logic [7:0]  latch, latch_next;

  logic [7:0]        pal_mem [PALETTE_BYTES];
  logic [PAL_AW-1:0] pal_idx;
  logic [7:0]        pal_rdata;
  logic              pal_we;

  logic              spr_we;
  logic [SPR_AW-1:0] spr_raddr;
  logic [7:0]        spr_rdata;
  logic [7:0]        spr_view;

  logic [13:0] a14;
  logic        is_pal;
  logic [14:0] cur_stepped;
  logic [14:0] tmp_hi_load;

  // Sprite memory, read ahead at the address the next beat will see;
  // without an advance the address holds
  assign spr_raddr = rst ? '0 :
                     (advance ? spr_addr_next[SPR_AW-1:0] : spr_addr[SPR_AW-1:0]);

  vri_sprite_mem #(
    .SPRITE_MEM_BYTES(SPRITE_MEM_BYTES)
  ) u_spr (
    .clk  (clk),
    .we   (advance & spr_we),
    .waddr(spr_addr[SPR_AW-1:0]),
    .wdata(item.write_byte),
    .raddr(spr_raddr),
    .rdata(spr_rdata)
  );

  // Address decode for the data port
  assign a14         = cur[13:0];
  assign is_pal      = (a14 >= PAL_BASE);
  assign cur_stepped = cur + (ctrl[CTRL_INC_BIT] ? STEP_DOWN : STEP_ACROSS);
  assign tmp_hi_load = {tmp[14:8], item.write_byte};

  // Palette index with the backdrop mirrors folded down
  always_comb begin
    pal_idx = a14[PAL_AW-1:0];
    if ((pal_idx & PAL_AW'(PAL_MIR_SEL)) == PAL_AW'(PAL_MIR_HIT)) begin
      pal_idx[PAL_AW-1] = 1'b0;
    end
  end
  assign pal_rdata = pal_mem[pal_idx];

  // Attribute bytes read back with the unused bits cleared
  assign spr_view = (spr_addr[1:0] == ATTR_SLOT) ? (spr_rdata & ATTR_MASK) : spr_rdata;

  // Next state and result for one beat
  always_comb begin
    ctrl_next     = ctrl;
    mask_next     = mask;
    vblank_next   = vblank;
    spr_addr_next = spr_addr;
    cur_next      = cur;
    tmp_next      = tmp;
    fine_x_next   = fine_x;
    toggle_next   = toggle;
    rd_buf_next   = rd_buf;
    latch_next    = latch;
    spr_we        = 1'b0;
    pal_we        = 1'b0;
    result        = '0;

    unique case (item.action)
      ACT_READ: begin
        case (item.reg_sel)
          REG_STATUS: begin
            latch_next  = {vblank, item.sprite_flags[0], item.sprite_flags[1], latch[4:0]};
            vblank_next = 1'b0;
            toggle_next = 1'b0;
          end
          REG_OAMDATA: begin
            latch_next = spr_view;
          end
          REG_DATA: begin
            cur_next = cur_stepped;
            if (is_pal) begin
              rd_buf_next = pal_rdata;
              latch_next  = {latch[7:6], pal_rdata[5:0]};
            end else begin
              rd_buf_next     = item.ext_byte;
              latch_next      = rd_buf;
              result.ext_read = 1'b1;
              result.ext_addr = a14;
            end
          end
          default: ;
        endcase
      end
      ACT_WRITE: begin
        latch_next = item.write_byte;
        case (item.reg_sel)
          REG_CTRL: begin
            ctrl_next = item.write_byte;
            tmp_next  = {tmp[14:12], item.write_byte[1:0], tmp[9:0]};
          end
          REG_MASK: begin
            mask_next = item.write_byte;
          end
          REG_OAMADDR: begin
            spr_addr_next = item.write_byte;
          end
          REG_OAMDATA: begin
            if (item.oam_write_ok) begin
              spr_we        = 1'b1;
              spr_addr_next = spr_addr + 8'd1;
            end
          end
          REG_SCROLL: begin
            toggle_next = ~toggle;
            if (!toggle) begin
              fine_x_next = item.write_byte[2:0];
              tmp_next    = {tmp[14:5], item.write_byte[7:3]};
            end else begin
              tmp_next = {item.write_byte[2:0], tmp[11:10], item.write_byte[7:3], tmp[4:0]};
            end
          end
          REG_ADDR: begin
            toggle_next = ~toggle;
            if (!toggle) begin
              tmp_next = {1'b0, item.write_byte[5:0], tmp[7:0]};
            end else begin
              tmp_next = tmp_hi_load;
              cur_next = tmp_hi_load;
            end
          end
          REG_DATA: begin
            cur_next = cur_stepped;
            if (is_pal) begin
              pal_we = 1'b1;
            end else begin
              result.ext_write = 1'b1;
              result.ext_addr  = a14;
              result.ext_data  = item.write_byte;
            end
          end
          default: ;
        endcase
      end
      ACT_VBLANK: begin
        vblank_next      = 1'b1;
        result.nmi_pulse = ctrl[CTRL_NMI_BIT];
      end
      ACT_PRERENDER: begin
        vblank_next = 1'b0;
      end
    endcase

    // Non-palette data reads return the old buffer; everything else the latch after the beat
    if ((item.action == ACT_READ) && (item.reg_sel == REG_DATA) && !is_pal) begin
      result.read_byte = rd_buf;
    end else if ((item.action == ACT_READ) && (item.reg_sel == REG_OAMDATA)) begin
      result.read_byte = spr_view;
    end else begin
      result.read_byte = latch_next;
    end
    result.cur_addr      = cur_next;
    result.tmp_addr      = tmp_next;
    result.fine_scroll_x = fine_x_next;
    result.ctrl_value    = ctrl_next;
    result.mask_value    = mask_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl     <= '0;
      mask     <= '0;
      vblank   <= 1'b0;
      spr_addr <= '0;
      cur      <= '0;
      tmp      <= '0;
      fine_x   <= '0;
      toggle   <= 1'b0;
      rd_buf   <= '0;
      latch    <= '0;
    end else if (advance) begin
      ctrl     <= ctrl_next;
      mask     <= mask_next;
      vblank   <= vblank_next;
      spr_addr <= spr_addr_next;
      cur      <= cur_next;
      tmp      <= tmp_next;
      fine_x   <= fine_x_next;
      toggle   <= toggle_next;
      rd_buf   <= rd_buf_next;
      latch    <= latch_next;
    end
  end

  // Palette storage
  always_ff @(posedge clk) begin
    if (advance && pal_we) begin
      pal_mem[pal_idx] <= item.write_byte;
    end
  end

endmodule

### rtl/video_register_interface.sv
`timescale 1ns / 1ps
// Path: input register, then update logic into the result register.
// Throughput: one beat per cycle while the result side is not stalled; the
//   sprite memory read is fetched ahead at the next sprite address, so its
//   registered read never stalls.
// Reset: synchronous rst clears the valid flags and core state registers;
//   sprite and palette memory and the beat data registers hold what was last written.
// ----------------------------------------------------------------------------
// video_register_interface
// CPU-side register file of a tile video processor with loopy scroll
// addressing, behind a stream handshake on each side.
// ----------------------------------------------------------------------------
module video_register_interface
  import vri_pkg::*;
#(
  parameter int SPRITE_MEM_BYTES = SPRITE_MEM_BYTES_DEF,
  parameter int PALETTE_BYTES    = PALETTE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // write_byte, ext_byte, oam_write_ok, sprite_flags, zero pad
  input  logic [4:0]  s_tuser,   // action, reg_sel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // read_byte, ext_addr, ext_data, nmi_pulse, cur_addr,
                                 // tmp_addr, fine_scroll_x, ctrl_value, mask_value
  output logic [1:0]  m_tuser    // ext_read, ext_write
);

  logic      in_valid;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  out_item_t result;
  logic      advance;

  // Beat moves into the result register when that register is free or draining
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.action       <= action_t'(s_tuser[1:0]);
      in_item.reg_sel      <= s_tuser[4:2];
      in_item.write_byte   <= s_tdata[7:0];
      in_item.ext_byte     <= s_tdata[15:8];
      in_item.oam_write_ok <= s_tdata[16];
      in_item.sprite_flags <= s_tdata[18:17];
    end
  end

  vri_core #(
    .SPRITE_MEM_BYTES(SPRITE_MEM_BYTES),
    .PALETTE_BYTES   (PALETTE_BYTES)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .advance(advance),
    .item   (in_item),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  // Output beat packing
  assign m_tvalid = out_valid;
  assign m_tuser  = {out_item.ext_write, out_item.ext_read};
  assign m_tdata  = {out_item.mask_value, out_item.ctrl_value, out_item.fine_scroll_x,
                     out_item.tmp_addr, out_item.cur_addr, out_item.nmi_pulse,
                     out_item.ext_data, out_item.ext_addr, out_item.read_byte};

endmodule

### rtl/vri_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vri_checker
// Port-level checks on the video register interface result stream.
// ----------------------------------------------------------------------------
module vri_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // No result beat right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled beat stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  // Never both an external read and write
  a_one_access: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("external read and write in one beat");

  // Address and data are zero when no external access happens
  a_idle_bus: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] && !m_tuser[1] |-> m_tdata[29:8] == 22'd0)
    else $error("external address or data set without an access");

  // An interrupt only with the enable bit in control
  a_nmi_enable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[30] |-> m_tdata[71])
    else $error("interrupt pulse with interrupts disabled");

endmodule

bind video_register_interface vri_checker u_vri_checker (.*);

### tb/tb_video_register_interface.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_video_register_interface
// Self-checking bench for the video register interface. CPU bus accesses and
// timing events are sent as stream beats. A behavioral model of the register
// file runs alongside and queues the expected result for each accepted beat.
// Every result beat is compared field by field. Both stream sides idle and
// stall at random, with one stretch that runs at full rate.
// ----------------------------------------------------------------------------
module tb_video_register_interface;
  import vri_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_BEATS = 515;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // write_byte, ext_byte, oam_write_ok, sprite_flags, zero pad
  logic [4:0]  s_tuser = '0;   // action, reg_sel
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;        // read_byte, ext_addr, ext_data, nmi_pulse, cur_addr,
                               // tmp_addr, fine_scroll_x, ctrl_value, mask_value
  logic [1:0]  m_tuser;        // ext_read, ext_write

  // Register file model state
  logic [7:0]  ctrl_byte;
  logic [7:0]  mask_byte;
  logic        vblank_set;
  logic [7:0]  oam_ptr;
  logic [7:0]  oam_bytes [256];
  bit          oam_seen  [256];
  logic [7:0]  pal_bytes [32];
  bit          pal_seen  [32];
  logic [14:0] v_addr;
  logic [14:0] t_addr;
  logic [2:0]  x_fine;
  logic        second_write;
  logic [7:0]  data_buf;
  logic [7:0]  bus_hold;

  out_item_t   result_q [$];
  int unsigned beats_sent;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  bit          steady_run;

  video_register_interface u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side backpressure
  always @(negedge clk) begin
    if (steady_run) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= 17);
    end
  end

  // Hang detection: no beat moved on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Palette slot with the sprite-backdrop mirrors folded down
  function automatic logic [4:0] pal_slot(logic [13:0] a);
    logic [4:0] s;
    s = a[4:0];
    if ((s & PAL_MIR_SEL) == PAL_MIR_HIT) s[4] = 1'b0;
    return s;
  endfunction

  function automatic logic [14:0] addr_step();
    return ctrl_byte[CTRL_INC_BIT] ? STEP_DOWN : STEP_ACROSS;
  endfunction

  // Apply one bus access or event to the model, return the result beat
  function automatic out_item_t apply_cpu_access(in_item_t it);
    out_item_t   r;
    logic [13:0] vram;
    logic [7:0]  v;
    r = '0;
    vram = v_addr[13:0];
    case (it.action)
      ACT_READ: begin
        r.read_byte = bus_hold;
        case (it.reg_sel)
          REG_STATUS: begin
            bus_hold = {vblank_set, it.sprite_flags[0], it.sprite_flags[1], bus_hold[4:0]};
            vblank_set = 1'b0;
            second_write = 1'b0;
            r.read_byte = bus_hold;
          end
          REG_OAMDATA: begin
            v = oam_bytes[oam_ptr];
            if (oam_ptr[1:0] == ATTR_SLOT) v = v & ATTR_MASK;
            bus_hold = v;
            r.read_byte = v;
          end
          REG_DATA: begin
            if (vram >= PAL_BASE) begin
              data_buf = pal_bytes[pal_slot(vram)];
              bus_hold = {bus_hold[7:6], data_buf[5:0]};
              r.read_byte = bus_hold;
            end else begin
              // buffered read: old buffer out, memory byte in
              r.read_byte = data_buf;
              data_buf = it.ext_byte;
              bus_hold = r.read_byte;
              r.ext_read = 1'b1;
              r.ext_addr = vram;
            end
            v_addr = v_addr + addr_step();
          end
          default: ;
        endcase
      end
      ACT_WRITE: begin
        bus_hold = it.write_byte;
        case (it.reg_sel)
          REG_CTRL: begin
            ctrl_byte = it.write_byte;
            t_addr[11:10] = it.write_byte[1:0];
          end
          REG_MASK:    mask_byte = it.write_byte;
          REG_OAMADDR: oam_ptr = it.write_byte;
          REG_OAMDATA: begin
            if (it.oam_write_ok) begin
              oam_bytes[oam_ptr] = it.write_byte;
              oam_seen[oam_ptr] = 1'b1;
              oam_ptr = oam_ptr + 8'd1;
            end
          end
          REG_SCROLL: begin
            if (!second_write) begin
              x_fine = it.write_byte[2:0];
              t_addr[4:0] = it.write_byte[7:3];
            end else begin
              t_addr[14:12] = it.write_byte[2:0];
              t_addr[9:5] = it.write_byte[7:3];
            end
            second_write = ~second_write;
          end
          REG_ADDR: begin
            if (!second_write) begin
              t_addr[14:8] = {1'b0, it.write_byte[5:0]};
            end else begin
              t_addr[7:0] = it.write_byte;
              v_addr = t_addr;
            end
            second_write = ~second_write;
          end
          REG_DATA: begin
            if (vram >= PAL_BASE) begin
              pal_bytes[pal_slot(vram)] = it.write_byte;
              pal_seen[pal_slot(vram)] = 1'b1;
            end else begin
              r.ext_write = 1'b1;
              r.ext_addr = vram;
              r.ext_data = it.write_byte;
            end
            v_addr = v_addr + addr_step();
          end
          default: ;
        endcase
        r.read_byte = bus_hold;
      end
      ACT_VBLANK: begin
        vblank_set = 1'b1;
        r.nmi_pulse = ctrl_byte[CTRL_NMI_BIT];
        r.read_byte = bus_hold;
      end
      default: begin
        vblank_set = 1'b0;
        r.read_byte = bus_hold;
      end
    endcase
    r.cur_addr = v_addr;
    r.tmp_addr = t_addr;
    r.fine_scroll_x = x_fine;
    r.ctrl_value = ctrl_byte;
    r.mask_value = mask_byte;
    return r;
  endfunction

  task automatic flag_error(string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    error_count++;
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      flag_error($sformatf("%s mismatch: got %0h expected %0h", name, got, want));
    end
  endtask

  // Send one beat; the model runs when the beat is taken
  task automatic send_item(in_item_t it);
    @(negedge clk);
    while (!steady_run && $urandom_range(0, 99) < 17) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    // never read sprite or palette bytes that hold nothing yet
    if (it.action == ACT_READ && it.reg_sel == REG_OAMDATA && !oam_seen[oam_ptr]) begin
      it.action = ACT_WRITE;
      it.oam_write_ok = 1'b1;
    end
    if (it.action == ACT_READ && it.reg_sel == REG_DATA && v_addr[13:0] >= PAL_BASE
        && !pal_seen[pal_slot(v_addr[13:0])]) begin
      it.action = ACT_WRITE;
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, it.sprite_flags, it.oam_write_ok, it.ext_byte, it.write_byte};
    s_tuser  <= {it.reg_sel, it.action};
    do @(posedge clk); while (!s_tready);
    result_q.push_back(apply_cpu_access(it));
    beats_sent++;
  endtask

  task automatic cpu_access(action_t act, logic [2:0] sel, logic [7:0] wb, bit oam_ok);
    in_item_t it;
    it.action       = act;
    it.reg_sel      = sel;
    it.write_byte   = wb;
    it.ext_byte     = any_byte();
    it.oam_write_ok = oam_ok;
    it.sprite_flags = 2'($urandom_range(0, 3));
    send_item(it);
  endtask

  // Result checker
  always @(posedge clk) begin : result_check
    out_item_t want;
    out_item_t got;
    if (!rst && m_tvalid && m_tready) begin
      if (result_q.size() == 0) begin
        flag_error($sformatf("result beat with nothing expected, tdata %h", m_tdata));
      end else begin
        want = result_q.pop_front();
        got.read_byte     = m_tdata[7:0];
        got.ext_addr      = m_tdata[21:8];
        got.ext_data      = m_tdata[29:22];
        got.nmi_pulse     = m_tdata[30];
        got.cur_addr      = m_tdata[45:31];
        got.tmp_addr      = m_tdata[60:46];
        got.fine_scroll_x = m_tdata[63:61];
        got.ctrl_value    = m_tdata[71:64];
        got.mask_value    = m_tdata[79:72];
        got.ext_read      = m_tuser[0];
        got.ext_write     = m_tuser[1];
        compare_field("read_byte", got.read_byte, want.read_byte);
        compare_field("ext_read", got.ext_read, want.ext_read);
        compare_field("ext_write", got.ext_write, want.ext_write);
        compare_field("ext_addr", got.ext_addr, want.ext_addr);
        compare_field("ext_data", got.ext_data, want.ext_data);
        compare_field("nmi_pulse", got.nmi_pulse, want.nmi_pulse);
        compare_field("cur_addr", got.cur_addr, want.cur_addr);
        compare_field("tmp_addr", got.tmp_addr, want.tmp_addr);
        compare_field("fine_scroll_x", got.fine_scroll_x, want.fine_scroll_x);
        compare_field("ctrl_value", got.ctrl_value, want.ctrl_value);
        compare_field("mask_value", got.mask_value, want.mask_value);
      end
    end
  end

  // Write-only registers read back the open bus, zero after reset
  task automatic test_write_only_reads();
    cpu_access(ACT_READ, REG_CTRL, 8'h00, 1'b1);
    cpu_access(ACT_READ, REG_MASK, 8'hFF, 1'b1);
    cpu_access(ACT_READ, REG_OAMADDR, 8'h00, 1'b1);
    cpu_access(ACT_READ, REG_SCROLL, 8'hFF, 1'b1);
    cpu_access(ACT_READ, REG_ADDR, 8'h00, 1'b1);
  endtask

  // NMI enable, vblank set and clear, status write only loads the bus
  task automatic test_control_and_status();
    cpu_access(ACT_WRITE, REG_CTRL, 8'hFF, 1'b1);
    cpu_access(ACT_VBLANK, REG_CTRL, 8'h00, 1'b1);
    cpu_access(ACT_READ, REG_STATUS, 8'h00, 1'b1);
    cpu_access(ACT_WRITE, REG_CTRL, 8'h00, 1'b1);
    cpu_access(ACT_VBLANK, REG_CTRL, 8'h00, 1'b1);
    cpu_access(ACT_PRERENDER, REG_CTRL, 8'h00, 1'b1);
    cpu_access(ACT_WRITE, REG_STATUS, 8'hFF, 1'b1);
    cpu_access(ACT_WRITE, REG_MASK, 8'hFF, 1'b1);
  endtask

  // Scroll pair, 6-bit high address, palette write, mirrored palette read,
  // buffered memory read
  task automatic test_scroll_and_data_port();
    cpu_access(ACT_WRITE, REG_SCROLL, 8'hFF, 1'b1);
    cpu_access(ACT_WRITE, REG_SCROLL, 8'hFF, 1'b1);
    cpu_access(ACT_WRITE, REG_ADDR, 8'hFF, 1'b1);
    cpu_access(ACT_WRITE, REG_ADDR, 8'h00, 1'b1);
    cpu_access(ACT_WRITE, REG_DATA, 8'hFF, 1'b1);
    cpu_access(ACT_WRITE, REG_ADDR, 8'h3F, 1'b1);
    cpu_access(ACT_WRITE, REG_ADDR, 8'h10, 1'b1);
    cpu_access(ACT_READ, REG_DATA, 8'h00, 1'b1);
    cpu_access(ACT_WRITE, REG_ADDR, 8'h00, 1'b1);
    cpu_access(ACT_WRITE, REG_ADDR, 8'h00, 1'b1);
    cpu_access(ACT_READ, REG_DATA, 8'h00, 1'b1);
  endtask

  // Sprite writes with wrap, blocked write, attribute mask on read
  task automatic test_sprite_memory();
    cpu_access(ACT_WRITE, REG_OAMADDR, 8'hFE, 1'b1);
    cpu_access(ACT_WRITE, REG_OAMDATA, 8'hFF, 1'b1);
    cpu_access(ACT_WRITE, REG_OAMDATA, 8'h5A, 1'b0);
    cpu_access(ACT_WRITE, REG_OAMDATA, 8'h5A, 1'b1);
    cpu_access(ACT_WRITE, REG_OAMADDR, 8'hFE, 1'b1);
    cpu_access(ACT_READ, REG_OAMDATA, 8'h00, 1'b1);
    cpu_access(ACT_WRITE, REG_OAMADDR, 8'hFF, 1'b1);
    cpu_access(ACT_READ, REG_OAMDATA, 8'h00, 1'b1);
  endtask

  // Mostly well-formed register sequences with random content, plus noise
  task automatic test_random_traffic();
    int unsigned stop_at;
    int unsigned pick;
    logic [7:0]  hi_byte;
    logic [7:0]  oam_start;
    stop_at = beats_sent + RANDOM_BEATS;
    while (beats_sent < stop_at) begin
      steady_run = (beats_sent + 400 < stop_at) && (beats_sent + 280 >= stop_at);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        // scroll pair, toggle cleared first half the time
        if ($urandom_range(0, 1)) cpu_access(ACT_READ, REG_STATUS, any_byte(), 1'b1);
        cpu_access(ACT_WRITE, REG_SCROLL, any_byte(), 1'b1);
        cpu_access(ACT_WRITE, REG_SCROLL, any_byte(), 1'b1);
      end else if (pick < 45) begin
        // address pair then a burst on the data port
        if ($urandom_range(0, 1)) cpu_access(ACT_READ, REG_STATUS, any_byte(), 1'b1);
        if ($urandom_range(0, 3) == 0) cpu_access(ACT_WRITE, REG_CTRL, any_byte(), 1'b1);
        hi_byte = any_byte();
        if ($urandom_range(0, 2) == 0) hi_byte[5:0] = 6'h3F;
        cpu_access(ACT_WRITE, REG_ADDR, hi_byte, 1'b1);
        cpu_access(ACT_WRITE, REG_ADDR, any_byte(), 1'b1);
        repeat ($urandom_range(1, 8)) begin
          cpu_access($urandom_range(0, 1) ? ACT_READ : ACT_WRITE, REG_DATA, any_byte(),
                     1'b1);
        end
      end else if (pick < 62) begin
        // sprite block fill and read back
        oam_start = any_byte();
        if ($urandom_range(0, 1)) oam_start[7:4] = 4'h0;
        cpu_access(ACT_WRITE, REG_OAMADDR, oam_start, 1'b1);
        repeat ($urandom_range(1, 4)) begin
          cpu_access(ACT_WRITE, REG_OAMDATA, any_byte(), ($urandom_range(0, 9) != 0));
        end
        cpu_access(ACT_WRITE, REG_OAMADDR, oam_start + 8'($urandom_range(0, 3)), 1'b1);
        repeat ($urandom_range(1, 3)) begin
          cpu_access(ACT_READ, REG_OAMDATA, any_byte(), ($urandom_range(0, 9) != 0));
        end
      end else if (pick < 75) begin
        // frame timing: vblank, status poll, prerender
        if ($urandom_range(0, 1)) cpu_access(ACT_WRITE, REG_CTRL, any_byte(), 1'b1);
        cpu_access(ACT_VBLANK, 3'($urandom_range(0, 7)), any_byte(), 1'b1);
        if ($urandom_range(0, 2) == 0) begin
          cpu_access(ACT_PRERENDER, 3'($urandom_range(0, 7)), any_byte(), 1'b1);
        end
        cpu_access(ACT_READ, REG_STATUS, any_byte(), 1'b1);
      end else if (pick < 85) begin
        cpu_access(ACT_WRITE, $urandom_range(0, 1) ? REG_CTRL : REG_MASK, any_byte(), 1'b1);
      end else begin
        cpu_access(action_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), any_byte(),
                   ($urandom_range(0, 1) != 0));
      end
    end
    steady_run = 1'b0;
  endtask

  initial begin
    ctrl_byte    = '0;
    mask_byte    = '0;
    vblank_set   = 1'b0;
    oam_ptr      = '0;
    v_addr       = '0;
    t_addr       = '0;
    x_fine       = '0;
    second_write = 1'b0;
    data_buf     = '0;
    bus_hold     = '0;
    beats_sent   = 0;
    steady_run   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_write_only_reads();
    test_control_and_status();
    test_scroll_and_data_port();
    test_sprite_memory();
    test_random_traffic();

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
rtl/vri_pkg.sv
rtl/vri_sprite_mem.sv
rtl/vri_core.sv
rtl/video_register_interface.sv
rtl/vri_checker.sv
tb/tb_video_register_interface.sv
